// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Clocked on clk, quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/bbta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbta_pkg;

	localparam int ID_W           = 6;
	localparam int TKT_W          = 4;
	localparam int STATUS_W       = 2;
	localparam int REQUESTERS_DEF = 64;

	localparam logic [TKT_W-1:0] LIMIT_RESET = 4'd10;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ISSUED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} seq_state_t;

	// Scan unit control
	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

	// Ticket store write control
	typedef struct packed {
		logic set;
		logic clr;
	} wr_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bbta_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbta_store #(
	parameter int REQUESTERS = bbta_pkg::REQUESTERS_DEF,
	localparam int IDX_W = $clog2(REQUESTERS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rd_en,
	input  wire logic [IDX_W-1:0]           rd_addr,
	output logic [bbta_pkg::TKT_W-1:0]      rd_tkt,
	input  wire bbta_pkg::wr_ctl_t          wr,
	input  wire logic [IDX_W-1:0]           wr_addr,
	input  wire logic [bbta_pkg::TKT_W-1:0] wr_data
);
	import bbta_pkg::*;

	logic [TKT_W-1:0]      mem [REQUESTERS];
	logic [REQUESTERS-1:0] vld_q;
	logic [TKT_W-1:0]      rdata_q;
	logic                  rvld_q;

	always_ff @(posedge clk) begin
		if (wr.set) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// entry valid bits: an entry never written or released reads as no ticket
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.set) begin
				vld_q[wr_addr] <= 1'b1;
			end else if (wr.clr) begin
				vld_q[wr_addr] <= 1'b0;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_tkt = rvld_q ? rdata_q : '0;

	`ASSERT_NEVER(a_wr_set_clr, wr.set && wr.clr, "store set and clear in same cycle")
	`ASSERT_NEVER(a_wr_during_rd, (wr.set || wr.clr) && rd_en, "store write during scan read")
	`ASSERT_CLK(a_set_nonzero, wr.set |-> (wr_data != '0), "store written with zero ticket")

endmodule

`default_nettype wire

// ===== rtl/core/bbta_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbta_scan #(
	parameter int REQUESTERS = bbta_pkg::REQUESTERS_DEF,
	localparam int IDX_W = $clog2(REQUESTERS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bbta_pkg::scan_ctl_t        ctl,
	input  wire logic [IDX_W-1:0]           idx,
	input  wire logic [bbta_pkg::TKT_W-1:0] tkt,
	input  wire logic [IDX_W-1:0]           own_idx,
	input  wire logic                       own_en,
	output logic [bbta_pkg::TKT_W-1:0]      max_tkt,
	output logic [bbta_pkg::TKT_W-1:0]      own_tkt,
	output logic [bbta_pkg::TKT_W-1:0]      best_tkt,
	output logic [IDX_W-1:0]                best_idx,
	output logic                            found
);
	import bbta_pkg::*;

	logic [TKT_W-1:0] max_q;
	logic [TKT_W-1:0] own_q;
	logic [TKT_W-1:0] best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             found_q;
	logic             is_own;
	logic             take_best;

	// the requester's own entry is kept apart from the holder search; it is
	// merged back once its new value is known
	assign is_own    = own_en && (idx == own_idx);
	assign take_best = (tkt != '0) && !is_own && (!found_q || (tkt < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q      <= '0;
			own_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			found_q    <= 1'b0;
		end else if (ctl.clear) begin
			max_q   <= '0;
			own_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.sample) begin
			if (tkt > max_q) begin
				max_q <= tkt;
			end
			if (is_own) begin
				own_q <= tkt;
			end
			if (take_best) begin
				best_q     <= tkt;
				best_idx_q <= idx;
				found_q    <= 1'b1;
			end
		end
	end

	assign max_tkt  = max_q;
	assign own_tkt  = own_q;
	assign best_tkt = best_q;
	assign best_idx = best_idx_q;
	assign found    = found_q;

	`ASSERT_CLK(a_best_nonzero, found_q |-> (best_q != '0), "holder found with zero ticket")
	`ASSERT_CLK(a_best_le_max, found_q |-> (best_q <= max_q), "holder ticket above maximum")
	`ASSERT_CLK(a_own_le_max, own_q <= max_q, "own ticket above maximum")

endmodule

`default_nettype wire

// ===== rtl/core/bounded_bakery_ticket_arbiter.sv =====
// Bounded bakery ticket arbiter: one ticket per requester, zero means none.
// Input channel (in_valid/in_ready): opcode 0 asks for a ticket, 1 releases
// it, for requester_id. A request gets the largest ticket in the table plus
// one if that does not exceed ticket_limit, otherwise it is refused.
// Output channel (out_valid/out_ready): status, the requester's ticket after
// the item, and the current holder (smallest nonzero ticket, lower index wins).
// Config channel (cfg_valid/cfg_ready/cfg_data): writes ticket_limit, always
// ready; write it only while no item is in flight.
// Sequence: each item makes one scan of the ticket memory through its one
// read port and one compare unit, then the last registered read drains, then
// the write-back step runs. Only after that does the sequencer return to
// idle, so a new item is not taken before the last one is written back.
// in_ready is high only while the sequencer is idle; the next item may be
// accepted while a result still waits in the output register.
// If the receiver stalls, the finished item holds in the write-back step
// until the output register frees up; nothing is dropped.
// Reset: all tickets cleared (valid bits), ticket_limit returns to 10,
// output register empty. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bounded_bakery_ticket_arbiter #(
	parameter int REQUESTERS = bbta_pkg::REQUESTERS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// config
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bbta_pkg::TKT_W-1:0]    cfg_data,
	// input items
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          opcode,
	input  wire logic [bbta_pkg::ID_W-1:0]     requester_id,
	// result items
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [bbta_pkg::STATUS_W-1:0]      status,
	output logic [bbta_pkg::TKT_W-1:0]         issued_ticket,
	output logic                               holder_valid,
	output logic [bbta_pkg::ID_W-1:0]          holder_id
);
	import bbta_pkg::*;

	localparam int IDX_W = $clog2(REQUESTERS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REQUESTERS - 1);

	seq_state_t state_q, state_d;

	logic [TKT_W-1:0] limit_q;
	logic             op_q;
	logic [ID_W-1:0]  id_q;
	logic [IDX_W-1:0] id_idx_q;
	logic             in_range_q;
	logic [IDX_W-1:0] addr_q;

	// read pipeline: sample flag and index follow the registered memory read
	logic             sample_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             accept;
	logic             out_free;
	logic             finish;
	logic             rd_en;
	scan_ctl_t        scan_ctl;
	wr_ctl_t          wr_ctl;

	logic [TKT_W-1:0] rd_tkt;
	logic [TKT_W-1:0] max_tkt;
	logic [TKT_W-1:0] own_tkt;
	logic [TKT_W-1:0] best_tkt;
	logic [IDX_W-1:0] best_idx;
	logic             found;

	logic [TKT_W:0]      next_tkt;
	logic                grant;
	logic [TKT_W-1:0]    new_tkt;
	logic                own_wins;
	logic [STATUS_W-1:0] res_status;
	logic [TKT_W-1:0]    res_ticket;
	logic                res_hvalid;
	logic [ID_W-1:0]     res_hid;

	logic [STATUS_W-1:0] status_q;
	logic [TKT_W-1:0]    ticket_q;
	logic                hvalid_q;
	logic [ID_W-1:0]     hid_q;
	logic                out_valid_q;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == S_FIN) && out_free;

	// ---------------- config ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (addr_q == LAST_IDX) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		rd_en           = 1'b0;
		scan_ctl.clear  = 1'b0;
		scan_ctl.sample = sample_s1;
		unique case (state_q)
			S_IDLE: begin
				in_ready       = 1'b1;
				scan_ctl.clear = in_valid;
			end
			S_SCAN: begin
				rd_en = 1'b1;
			end
			S_DRAIN, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			addr_q    <= '0;
			sample_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			sample_s1 <= rd_en;
			if (accept) begin
				addr_q <= '0;
			end else if (rd_en && (addr_q != LAST_IDX)) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (accept) begin
			op_q       <= opcode;
			id_q       <= requester_id;
			id_idx_q   <= IDX_W'(requester_id);
			in_range_q <= (32'(requester_id) < REQUESTERS);
		end
	end

	// ---------------- datapath ----------------
	bbta_store #(
		.REQUESTERS (REQUESTERS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_tkt  (rd_tkt),
		.wr      (wr_ctl),
		.wr_addr (id_idx_q),
		.wr_data (new_tkt)
	);

	bbta_scan #(
		.REQUESTERS (REQUESTERS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (idx_s1),
		.tkt      (rd_tkt),
		.own_idx  (id_idx_q),
		.own_en   (in_range_q),
		.max_tkt  (max_tkt),
		.own_tkt  (own_tkt),
		.best_tkt (best_tkt),
		.best_idx (best_idx),
		.found    (found)
	);

	// Decide the item from the scan totals. A full table (max 15) gives
	// 16 here, which no 4-bit limit admits.
	assign next_tkt = {1'b0, max_tkt} + 1'b1;
	assign grant    = (op_q == OP_REQUEST) && in_range_q && (next_tkt <= {1'b0, limit_q});

	always_comb begin
		if (op_q == OP_RELEASE) begin
			new_tkt = '0;
		end else if (grant) begin
			new_tkt = next_tkt[TKT_W-1:0];
		end else begin
			new_tkt = own_tkt;
		end
	end

	// merge the requester's updated entry into the holder search
	assign own_wins = in_range_q && (new_tkt != '0) &&
		(!found || (new_tkt < best_tkt) || ((new_tkt == best_tkt) && (id_idx_q < best_idx)));

	always_comb begin
		if (op_q == OP_RELEASE) begin
			res_status = ST_RELEASED;
		end else if (grant) begin
			res_status = ST_ISSUED;
		end else begin
			res_status = ST_REFUSED;
		end
		res_ticket = ((op_q == OP_REQUEST) && in_range_q) ? new_tkt : '0;
		res_hvalid = found || own_wins;
		if (own_wins) begin
			res_hid = id_q;
		end else if (found) begin
			res_hid = ID_W'(best_idx);
		end else begin
			res_hid = '0;
		end
	end

	assign wr_ctl.set = finish && grant;
	assign wr_ctl.clr = finish && (op_q == OP_RELEASE) && in_range_q;

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= res_status;
			ticket_q <= res_ticket;
			hvalid_q <= res_hvalid;
			hid_q    <= res_hid;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign issued_ticket = ticket_q;
	assign holder_valid  = hvalid_q;
	assign holder_id     = hid_q;

	`ASSERT_CLK(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN), "result without write-back")
	`ASSERT_CLK(a_no_holder_id, (out_valid_q && !hvalid_q) |-> (hid_q == '0), "holder id without holder")
	`ASSERT_CLK(a_issued_bounds, (out_valid_q && (status_q == ST_ISSUED)) |-> ((ticket_q != '0) && (ticket_q <= limit_q)), "issued ticket out of bounds")
	`ASSERT_CLK(a_issued_holder, (out_valid_q && (status_q == ST_ISSUED)) |-> hvalid_q, "ticket issued but no holder")

endmodule

`default_nettype wire

// ===== dv/bounded_bakery_ticket_arbiter_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the bounded bakery ticket arbiter.
// A tracker class mirrors the ticket table and the limit register. Every input item
// accepted at a clock edge is run through the tracker's copy of the table. The result
// that the item should produce goes on a queue. Each result accepted from the block is
// checked against the head of that queue.
module bounded_bakery_ticket_arbiter_tb;

	import bbta_pkg::*;

	localparam int NREQ        = REQUESTERS_DEF;
	localparam int LATENCY     = NREQ + 3;
	localparam int HOLD_CYCLES = 600;           // long receiver hold-off
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 270;
	localparam int ZERO_ITEMS  = 60;            // a zero limit refuses everything, keep it short

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [TKT_W-1:0]    ticket;
		logic                holder_valid;
		logic [ID_W-1:0]     holder_id;
	} ticket_result_t;

	// Shadow of the ticket table, plus the queue of results still owed by the block.
	class bakery_ticket_tracker;
		logic [TKT_W-1:0] tickets [NREQ];
		logic [TKT_W-1:0] limit;
		ticket_result_t   owed[$];
		int unsigned      mismatches;

		function new();
			foreach (tickets[i]) tickets[i] = '0;
			limit      = LIMIT_RESET;
			mismatches = 0;
		endfunction

		function void set_limit(logic [TKT_W-1:0] value);
			limit = value;
		endfunction

		// Apply one accepted item to the shadow table and queue its result.
		function void note_item(logic op, logic [ID_W-1:0] id);
			ticket_result_t   r;
			logic [TKT_W-1:0] top;
			logic [TKT_W:0]   next;
			logic [TKT_W-1:0] best;
			bit               found;
			bit               in_range;
			in_range = (int'(id) < NREQ);
			r.ticket = '0;
			if (op == OP_REQUEST) begin
				r.status = ST_REFUSED;
				if (in_range) begin
					top = '0;
					foreach (tickets[i])
						if (tickets[i] > top) top = tickets[i];
					// Largest plus one. Sixteen can never fit under a 4-bit limit.
					next = {1'b0, top} + 1'b1;
					if (next <= {1'b0, limit}) begin
						tickets[id] = next[TKT_W-1:0];
						r.status = ST_ISSUED;
					end
					// A refused holder keeps its old ticket and reports it.
					r.ticket = tickets[id];
				end
			end else begin
				if (in_range) tickets[id] = '0;
				r.status = ST_RELEASED;
			end
			// The holder is taken after the update: smallest nonzero ticket, lowest index.
			found = 0;
			best = '0;
			r.holder_id = '0;
			foreach (tickets[i]) begin
				if (tickets[i] != 0 && (!found || tickets[i] < best)) begin
					best = tickets[i];
					r.holder_id = i[ID_W-1:0];
					found = 1;
				end
			end
			r.holder_valid = found;
			owed.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [TKT_W-1:0] tkt,
				logic hv, logic [ID_W-1:0] hid);
			ticket_result_t r;
			if (owed.size() == 0) begin
				$error("result with no item outstanding: status %0d ticket %0d", st, tkt);
				mismatches++;
				return;
			end
			r = owed.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, st);
				mismatches++;
			end
			if (tkt !== r.ticket) begin
				$error("issued_ticket: expected %0d, actual %0d", r.ticket, tkt);
				mismatches++;
			end
			if (hv !== r.holder_valid) begin
				$error("holder_valid: expected %0d, actual %0d", r.holder_valid, hv);
				mismatches++;
			end
			if (hid !== r.holder_id) begin
				$error("holder_id: expected %0d, actual %0d", r.holder_id, hid);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return owed.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [TKT_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                opcode;
	logic [ID_W-1:0]     requester_id;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [TKT_W-1:0]    issued_ticket;
	logic                holder_valid;
	logic [ID_W-1:0]     holder_id;

	bakery_ticket_tracker tracker = new();

	bit no_idle;        // stretches where neither side inserts gaps
	bit hold_request;   // asks the receiver for one long hold-off

	bounded_bakery_ticket_arbiter #(.REQUESTERS(NREQ)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.requester_id  (requester_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.issued_ticket (issued_ticket),
		.holder_valid  (holder_valid),
		.holder_id     (holder_id)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Safety net. The slowest legal run is well under this.
	initial begin
		#20_000_000;
		$display("bounded_bakery_ticket_arbiter regression: fail");
		$finish;
	end

	// Mostly back to back or short gaps, with an occasional long one.
	function automatic int unsigned idle_cycles();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// All handshakes are sampled at the edge, before the drivers' nonblocking updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) tracker.set_limit(cfg_data);
			if (in_valid && in_ready) tracker.note_item(opcode, requester_id);
			if (out_valid && out_ready)
				tracker.check_result(status, issued_ticket, holder_valid, holder_id);
		end
	end

	// Receiver. Each loop pass starts on an edge and makes one assignment per edge.
	// The long hold-off is counted here, so the block fills up while the sender
	// keeps offering items.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = idle_cycles();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Called on an edge. Valid stays up between back-to-back items, so it is never
	// lowered and raised again in the same step.
	task automatic send_item(logic op, logic [ID_W-1:0] id);
		int unsigned gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		requester_id <= id;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering items and let every owed result come back. One edge first, so
	// the monitor has queued the item accepted at the current edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The limit is written only once the block is idle.
	task automatic write_limit(logic [TKT_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [TKT_W-1:0] lim;
		logic [ID_W-1:0]  pool_base;
		logic [ID_W-1:0]  id;
		logic             op;
		int unsigned      count;

		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		opcode       = 1'b0;
		requester_id = '0;
		no_idle      = 0;
		hold_request = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset limit of 10.
		send_item(OP_RELEASE, 6'd0);        // release without a ticket
		send_item(OP_REQUEST, 6'd63);       // top index gets ticket 1
		send_item(OP_REQUEST, 6'd0);        // ticket 2
		send_item(OP_REQUEST, 6'd0);        // holder asks again, 3 replaces 2
		send_item(OP_RELEASE, 6'd63);       // holder moves to index 0
		for (int k = 1; k <= 8; k++)
			send_item(OP_REQUEST, 6'(k * 7));   // climbs to 10, the last one is refused
		send_item(OP_REQUEST, 6'd0);        // refused holder keeps its ticket

		// Highest limit: fill the table to fifteen, then the next request is refused.
		write_limit(4'd15);
		for (int k = 1; k <= 6; k++)
			send_item(OP_REQUEST, 6'(k));
		send_item(OP_REQUEST, 6'd0);

		// Zero limit: every request is refused. Releases still work.
		write_limit(4'd0);
		send_item(OP_REQUEST, 6'd9);
		send_item(OP_RELEASE, 6'd0);
		send_item(OP_RELEASE, 6'd42);

		// Random phases. Most traffic comes from a small pool of requesters, so that
		// tickets are taken and given back often and the limit is actually reached.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       lim = 4'd1;
				1:       lim = 4'd15;
				2:       lim = 4'd0;
				default: lim = 4'($urandom_range(0, 15));
			endcase
			write_limit(lim);
			no_idle = (p == 3);
			if (p == 1) hold_request = 1;
			pool_base = 6'($urandom_range(0, 63));
			count = (lim == 0) ? ZERO_ITEMS : PHASE_ITEMS;
			for (int n = 0; n < count; n++) begin
				op = ($urandom_range(0, 99) < 55) ? OP_REQUEST : OP_RELEASE;
				if ($urandom_range(0, 3) != 0)
					id = pool_base + 6'($urandom_range(0, 7));
				else
					id = 6'($urandom_range(0, 63));
				send_item(op, id);
			end
		end

		in_valid <= 1'b0;
		no_idle = 0;
		@(posedge clk);
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("bounded_bakery_ticket_arbiter regression: pass");
		end else begin
			$display("bounded_bakery_ticket_arbiter regression: fail");
		end
		$finish;
	end

endmodule
